// File: rtl/core/nfha_pkg.sv
// Package: shared types, codes and defaults for the next-fit heap allocator.
package nfha_pkg;

  localparam int unsigned ARENA_BYTES_DEF  = 4096;
  localparam int unsigned WORD_BYTES_DEF   = 8;
  localparam int unsigned HEADER_BYTES_DEF = 24;
  localparam int unsigned MIN_ARENA        = 64;

  localparam int unsigned OFF_W  = 12;
  localparam int unsigned REQ_W  = 13;
  localparam int unsigned CPY_W  = 13;
  localparam int unsigned CFG_W  = 13;
  localparam logic [CFG_W-1:0] ARENA_CFG_RST = 13'd4096;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_INIT    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_OOM   = 2'd1,
    ST_MOVED = 2'd2
  } status_e;

  typedef struct packed {
    op_e              operation;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] block_offset;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0] result_offset;
    status_e          status;
    logic [CPY_W-1:0] copy_bytes;
  } out_item_t;

  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_LOAD,
    UOP_CLR,
    UOP_ALC_START,
    UOP_SCAN,
    UOP_ALC_TAKE,
    UOP_ALC_WS,
    UOP_ALC_WNP,
    UOP_RD_W,
    UOP_CHK,
    UOP_FR_MARK,
    UOP_FR_P,
    UOP_FR_P2,
    UOP_FR_P3,
    UOP_NX_RD,
    UOP_FR_N,
    UOP_FR_N2,
    UOP_FR_N3,
    UOP_RE_N,
    UOP_RE_CLR,
    UOP_RE_W,
    UOP_RE_NNP,
    UOP_RE_WW,
    UOP_SET_OFF
  } uop_e;

  typedef struct packed {
    uop_e    uop;
    logic    out_load;
    status_e out_status;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic off_zero;
    logic clr_last;
    logic fit;
    logic stop;
    logic alc_split;
    logic used;
    logic in_place;
    logic merge_prev;
    logic merge_next;
    logic grow_ok;
  } dp_stat_t;

endpackage

// File: rtl/core/nfha_datapath.sv
// Datapath: header memory, block registers, size arithmetic and result register.
module nfha_datapath #(
  parameter int unsigned ARENA_BYTES  = nfha_pkg::ARENA_BYTES_DEF,
  parameter int unsigned WORD_BYTES   = nfha_pkg::WORD_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = nfha_pkg::HEADER_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [nfha_pkg::CFG_W-1:0] cfg_wdata_i,
  input  nfha_pkg::in_item_t         in_item_i,
  input  nfha_pkg::dp_cmd_t          cmd_i,
  output nfha_pkg::dp_stat_t         stat_o,
  output nfha_pkg::out_item_t        out_item_o
);

  localparam int unsigned NWORDS = ARENA_BYTES / WORD_BYTES;
  localparam int unsigned IDX_W  = $clog2(NWORDS);
  localparam int unsigned SIZE_W = $clog2(ARENA_BYTES);
  localparam int unsigned WSH    = $clog2(WORD_BYTES);
  localparam int unsigned HDR    = (HEADER_BYTES + WORD_BYTES - 1) / WORD_BYTES * WORD_BYTES;
  localparam int unsigned HDRW   = HDR / WORD_BYTES;
  localparam int unsigned VAL_W  = ((SIZE_W > nfha_pkg::REQ_W) ? SIZE_W : nfha_pkg::REQ_W) + 2;

  typedef struct packed {
    logic [IDX_W-1:0]  prev;
    logic [IDX_W-1:0]  next;
    logic [SIZE_W-1:0] size;
    logic              free;
  } head_t;

  typedef struct packed {
    logic prev;
    logic next;
    logic size;
    logic free;
  } wmask_t;

  head_t mem_q [NWORDS];
  head_t rd_q;

  logic                         we;
  logic [IDX_W-1:0]             wa;
  head_t                        wd;
  wmask_t                       wm;
  logic [IDX_W-1:0]             ra;

  nfha_pkg::op_e                op_q;
  logic [VAL_W-1:0]             n_q;
  logic [nfha_pkg::OFF_W-1:0]   off_q;
  logic                         vo_q;
  logic [IDX_W-1:0]             w_q;
  head_t                        h_q;
  logic [IDX_W-1:0]             node_q;
  logic [IDX_W-1:0]             p_q;
  logic [IDX_W-1:0]             nx_q;
  logic [IDX_W-1:0]             nn_q;
  logic [VAL_W-1:0]             tot_q;
  logic [SIZE_W-1:0]            old_q;
  logic [IDX_W-1:0]             rover_q;
  logic [IDX_W-1:0]             clr_q;
  logic [IDX_W-1:0]             cnt_q;
  logic [nfha_pkg::OFF_W-1:0]   res_q;
  logic [nfha_pkg::CFG_W-1:0]   arena_q;
  nfha_pkg::out_item_t          out_q;

  logic [VAL_W-1:0]             req_x, req_r, n_in;
  logic [VAL_W-1:0]             off_x, off_d;
  logic                         vo_in;
  logic [VAL_W-1:0]             a0, a1, a2, a3;
  head_t                        init_h;
  logic [IDX_W-1:0]             s_alc, s_re;
  logic                         alc_split, re_split;
  logic                         fit, mp, mn;
  logic [VAL_W-1:0]             p_merged, n_merged;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] base,
                                                input logic [VAL_W-1:0] n);
    logic [VAL_W-1:0] s;
    s = VAL_W'(base) + VAL_W'(HDRW) + (n >> WSH);
    if (s >= VAL_W'(NWORDS)) s = s - VAL_W'(NWORDS);
    return IDX_W'(s);
  endfunction

  function automatic logic touches(input logic [IDX_W-1:0] a, input logic [SIZE_W-1:0] sz,
                                   input logic [IDX_W-1:0] b);
    return (VAL_W'(a) + VAL_W'(HDRW) + (VAL_W'(sz) >> WSH)) == VAL_W'(b);
  endfunction

  // request rounding and offset decode
  always_comb begin
    req_x = VAL_W'(in_item_i.request_bytes);
    req_r = req_x + VAL_W'(WORD_BYTES - 1);
    n_in  = (req_r >> WSH) << WSH;
    if (req_x < VAL_W'(WORD_BYTES)) n_in = VAL_W'(WORD_BYTES);
    off_x = VAL_W'(in_item_i.block_offset);
    off_d = off_x - VAL_W'(HDR);
    vo_in = (off_x >= VAL_W'(HDR)) && (off_d[WSH-1:0] == '0) &&
            ((off_d >> WSH) < VAL_W'(NWORDS));
  end

  // init block size
  always_comb begin
    a0 = VAL_W'(arena_q);
    a1 = (a0 > VAL_W'(ARENA_BYTES)) ? VAL_W'(ARENA_BYTES) : a0;
    a2 = (a1 >> WSH) << WSH;
    a3 = (a2 < VAL_W'(nfha_pkg::MIN_ARENA)) ? VAL_W'(nfha_pkg::MIN_ARENA) : a2;
    init_h      = '0;
    init_h.size = SIZE_W'(a3 - VAL_W'(HDR));
    init_h.free = 1'b1;
  end

  always_comb begin
    s_alc     = wrap_idx(node_q, n_q);
    s_re      = wrap_idx(w_q, n_q);
    alc_split = (VAL_W'(h_q.size) - n_q) >= VAL_W'(HDR + WORD_BYTES);
    re_split  = (tot_q - n_q) >= VAL_W'(HDR + WORD_BYTES);
    fit       = rd_q.free && (VAL_W'(rd_q.size) >= n_q);
    mp        = (p_q != w_q) && rd_q.free && touches(p_q, rd_q.size, w_q);
    mn        = (nx_q != w_q) && rd_q.free && touches(w_q, h_q.size, nx_q);
    p_merged  = VAL_W'(rd_q.size) + VAL_W'(HDR) + VAL_W'(h_q.size);
    n_merged  = VAL_W'(h_q.size) + VAL_W'(HDR) + VAL_W'(rd_q.size);
  end

  always_comb begin
    stat_o.op         = op_q;
    stat_o.off_zero   = off_q == '0;
    stat_o.clr_last   = clr_q == IDX_W'(NWORDS - 1);
    stat_o.fit        = fit;
    stat_o.stop       = (rd_q.next == rover_q) || (cnt_q == IDX_W'(NWORDS - 1));
    stat_o.alc_split  = alc_split;
    stat_o.used       = vo_q && (rd_q.size != '0) && !rd_q.free;
    stat_o.in_place   = n_q <= VAL_W'(rd_q.size);
    stat_o.merge_prev = mp;
    stat_o.merge_next = mn;
    stat_o.grow_ok    = mn && (n_merged >= n_q);
  end

  // memory port control
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    wm = '0;
    ra = rover_q;
    unique case (cmd_i.uop)
      nfha_pkg::UOP_CLR: begin
        we = 1'b1; wa = clr_q; wm = '1;
        wd = (clr_q == '0) ? init_h : '0;
      end
      nfha_pkg::UOP_SCAN:    ra = rd_q.next;
      nfha_pkg::UOP_ALC_TAKE: begin
        we = 1'b1; wa = node_q;
        wm.next = 1'b1; wm.size = 1'b1; wm.free = 1'b1;
        wd.next = alc_split ? s_alc : h_q.next;
        wd.size = alc_split ? SIZE_W'(n_q) : h_q.size;
      end
      nfha_pkg::UOP_ALC_WS: begin
        we = 1'b1; wa = s_alc; wm = '1;
        wd.prev = node_q;
        wd.next = h_q.next;
        wd.size = SIZE_W'(VAL_W'(h_q.size) - n_q - VAL_W'(HDR));
        wd.free = 1'b1;
      end
      nfha_pkg::UOP_ALC_WNP: begin
        we = 1'b1; wa = h_q.next; wm.prev = 1'b1; wd.prev = s_alc;
      end
      nfha_pkg::UOP_RD_W:    ra = w_q;
      nfha_pkg::UOP_FR_MARK: begin
        we = 1'b1; wa = w_q; wm.free = 1'b1; wd.free = 1'b1;
        ra = h_q.prev;
      end
      nfha_pkg::UOP_FR_P: begin
        we = mp; wa = p_q; wm.next = 1'b1; wm.size = 1'b1;
        wd.next = h_q.next; wd.size = SIZE_W'(p_merged);
      end
      nfha_pkg::UOP_FR_P2: begin
        we = 1'b1; wa = h_q.next; wm.prev = 1'b1; wd.prev = p_q;
      end
      nfha_pkg::UOP_FR_P3: begin
        we = 1'b1; wa = w_q; wm = '1;
      end
      nfha_pkg::UOP_NX_RD:   ra = h_q.next;
      nfha_pkg::UOP_FR_N: begin
        we = mn; wa = w_q; wm.next = 1'b1; wm.size = 1'b1;
        wd.next = rd_q.next; wd.size = SIZE_W'(n_merged);
      end
      nfha_pkg::UOP_FR_N2: begin
        we = 1'b1; wa = nn_q; wm.prev = 1'b1; wd.prev = w_q;
      end
      nfha_pkg::UOP_FR_N3, nfha_pkg::UOP_RE_CLR: begin
        we = 1'b1; wa = nx_q; wm = '1;
      end
      nfha_pkg::UOP_RE_W: begin
        we = re_split; wa = s_re; wm = '1;
        wd.prev = w_q;
        wd.next = nn_q;
        wd.size = SIZE_W'(tot_q - n_q - VAL_W'(HDR));
        wd.free = 1'b1;
      end
      nfha_pkg::UOP_RE_NNP: begin
        we = 1'b1; wa = nn_q; wm.prev = 1'b1;
        wd.prev = re_split ? s_re : w_q;
      end
      nfha_pkg::UOP_RE_WW: begin
        we = 1'b1; wa = w_q; wm.next = 1'b1; wm.size = 1'b1;
        wd.next = re_split ? s_re : nn_q;
        wd.size = re_split ? SIZE_W'(n_q) : SIZE_W'(tot_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      if (wm.prev) mem_q[wa].prev <= wd.prev;
      if (wm.next) mem_q[wa].next <= wd.next;
      if (wm.size) mem_q[wa].size <= wd.size;
      if (wm.free) mem_q[wa].free <= wd.free;
    end
    rd_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rover_q <= '0;
      arena_q <= nfha_pkg::ARENA_CFG_RST;
    end else begin
      if (cfg_we_i) arena_q <= cfg_wdata_i;
      unique case (cmd_i.uop)
        nfha_pkg::UOP_CLR:      rover_q <= '0;
        nfha_pkg::UOP_ALC_TAKE: rover_q <= alc_split ? s_alc : h_q.next;
        nfha_pkg::UOP_FR_N:     rover_q <= w_q;
        nfha_pkg::UOP_RE_WW:    if (rover_q == nx_q) rover_q <= re_split ? s_re : nn_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.uop)
      nfha_pkg::UOP_LOAD: begin
        op_q  <= in_item_i.operation;
        n_q   <= n_in;
        off_q <= in_item_i.block_offset;
        vo_q  <= vo_in;
        w_q   <= IDX_W'(off_d >> WSH);
        res_q <= '0;
        clr_q <= '0;
      end
      nfha_pkg::UOP_CLR:       clr_q <= clr_q + 1'b1;
      nfha_pkg::UOP_ALC_START: begin
        node_q <= rover_q;
        cnt_q  <= '0;
      end
      nfha_pkg::UOP_SCAN: begin
        cnt_q <= cnt_q + 1'b1;
        if (fit) h_q <= rd_q;
        else     node_q <= rd_q.next;
      end
      nfha_pkg::UOP_ALC_TAKE:
        res_q <= nfha_pkg::OFF_W'((VAL_W'(node_q) << WSH) + VAL_W'(HDR));
      nfha_pkg::UOP_CHK: begin
        h_q   <= rd_q;
        old_q <= rd_q.size;
      end
      nfha_pkg::UOP_FR_MARK:   p_q <= h_q.prev;
      nfha_pkg::UOP_FR_P:      if (mp) h_q.size <= SIZE_W'(p_merged);
      nfha_pkg::UOP_FR_P3:     w_q <= p_q;
      nfha_pkg::UOP_NX_RD:     nx_q <= h_q.next;
      nfha_pkg::UOP_FR_N:      nn_q <= rd_q.next;
      nfha_pkg::UOP_RE_N: begin
        nn_q  <= rd_q.next;
        tot_q <= n_merged;
      end
      nfha_pkg::UOP_RE_WW, nfha_pkg::UOP_SET_OFF: res_q <= off_q;
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_q.result_offset <= res_q;
      out_q.status        <= cmd_i.out_status;
      out_q.copy_bytes    <= (cmd_i.out_status == nfha_pkg::ST_MOVED) ?
                             nfha_pkg::CPY_W'(old_q) : '0;
    end
  end

  assign out_item_o = out_q;

endmodule

// File: rtl/core/nfha_ctrl.sv
// Controller: operation sequencer and output handshake for the heap allocator.
module nfha_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  nfha_pkg::dp_stat_t stat_i,
  output nfha_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_CLR, S_ALC0, S_SCAN, S_TAKE, S_WS, S_WNP,
    S_RDW, S_CHK, S_FMARK, S_FP, S_FP2, S_FP3, S_FNRD, S_FN, S_FN2, S_FN3,
    S_SETOFF, S_RNRD, S_RN, S_RCLR, S_RW, S_RNNP, S_RWW, S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic              moving_q, moving_d;
  nfha_pkg::status_e st_q, st_d;
  logic              out_valid_q, out_valid_d;

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d  = state_q;
    moving_d = moving_q;
    st_d     = st_q;
    cmd_o.uop        = nfha_pkg::UOP_NONE;
    cmd_o.out_load   = 1'b0;
    cmd_o.out_status = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.uop = nfha_pkg::UOP_LOAD;
          moving_d  = 1'b0;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.op)
          nfha_pkg::OP_ALLOC:   state_d = S_ALC0;
          nfha_pkg::OP_FREE:    state_d = S_RDW;
          nfha_pkg::OP_REALLOC: state_d = stat_i.off_zero ? S_ALC0 : S_RDW;
          nfha_pkg::OP_INIT:    state_d = S_CLR;
        endcase
      end
      S_CLR: begin
        cmd_o.uop = nfha_pkg::UOP_CLR;
        if (stat_i.clr_last) begin
          st_d = nfha_pkg::ST_DONE; state_d = S_DONE;
        end
      end
      S_ALC0: begin
        cmd_o.uop = nfha_pkg::UOP_ALC_START; state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.uop = nfha_pkg::UOP_SCAN;
        priority if (stat_i.fit) state_d = S_TAKE;
        else if (stat_i.stop) begin
          st_d = nfha_pkg::ST_OOM; state_d = S_DONE;
        end
      end
      S_TAKE, S_WNP: begin
        cmd_o.uop = (state_q == S_TAKE) ? nfha_pkg::UOP_ALC_TAKE : nfha_pkg::UOP_ALC_WNP;
        priority if (state_q == S_TAKE && stat_i.alc_split) state_d = S_WS;
        else if (moving_q) state_d = S_RDW;
        else begin
          st_d = nfha_pkg::ST_DONE; state_d = S_DONE;
        end
      end
      S_WS: begin
        cmd_o.uop = nfha_pkg::UOP_ALC_WS; state_d = S_WNP;
      end
      S_RDW: begin
        cmd_o.uop = nfha_pkg::UOP_RD_W; state_d = S_CHK;
      end
      S_CHK: begin
        cmd_o.uop = nfha_pkg::UOP_CHK;
        priority if (moving_q) state_d = S_FMARK;
        else if (stat_i.op == nfha_pkg::OP_FREE) begin
          if (stat_i.used) state_d = S_FMARK;
          else begin
            st_d = nfha_pkg::ST_DONE; state_d = S_DONE;
          end
        end else if (!stat_i.used) begin
          st_d = nfha_pkg::ST_OOM; state_d = S_DONE;
        end else if (stat_i.in_place) state_d = S_SETOFF;
        else state_d = S_RNRD;
      end
      S_FMARK: begin
        cmd_o.uop = nfha_pkg::UOP_FR_MARK; state_d = S_FP;
      end
      S_FP: begin
        cmd_o.uop = nfha_pkg::UOP_FR_P;
        state_d = stat_i.merge_prev ? S_FP2 : S_FNRD;
      end
      S_FP2: begin
        cmd_o.uop = nfha_pkg::UOP_FR_P2; state_d = S_FP3;
      end
      S_FP3: begin
        cmd_o.uop = nfha_pkg::UOP_FR_P3; state_d = S_FNRD;
      end
      S_FNRD: begin
        cmd_o.uop = nfha_pkg::UOP_NX_RD; state_d = S_FN;
      end
      S_FN, S_FN3: begin
        cmd_o.uop = (state_q == S_FN) ? nfha_pkg::UOP_FR_N : nfha_pkg::UOP_FR_N3;
        if (state_q == S_FN && stat_i.merge_next) state_d = S_FN2;
        else begin
          st_d    = moving_q ? nfha_pkg::ST_MOVED : nfha_pkg::ST_DONE;
          state_d = S_DONE;
        end
      end
      S_FN2: begin
        cmd_o.uop = nfha_pkg::UOP_FR_N2; state_d = S_FN3;
      end
      S_SETOFF, S_RWW: begin
        cmd_o.uop = (state_q == S_SETOFF) ? nfha_pkg::UOP_SET_OFF : nfha_pkg::UOP_RE_WW;
        st_d = nfha_pkg::ST_DONE; state_d = S_DONE;
      end
      S_RNRD: begin
        cmd_o.uop = nfha_pkg::UOP_NX_RD; state_d = S_RN;
      end
      S_RN: begin
        cmd_o.uop = nfha_pkg::UOP_RE_N;
        if (stat_i.grow_ok) state_d = S_RCLR;
        else begin
          moving_d = 1'b1; state_d = S_ALC0;
        end
      end
      S_RCLR: begin
        cmd_o.uop = nfha_pkg::UOP_RE_CLR; state_d = S_RW;
      end
      S_RW: begin
        cmd_o.uop = nfha_pkg::UOP_RE_W; state_d = S_RNNP;
      end
      S_RNNP: begin
        cmd_o.uop = nfha_pkg::UOP_RE_NNP; state_d = S_RWW;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      moving_q    <= 1'b0;
      st_q        <= nfha_pkg::ST_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      moving_q    <= moving_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/next_fit_heap_allocator.sv
// Top level: next-fit boundary-tag heap allocator with coalescing.
//
//  channel | direction | handshake              | payload
//  cfg     | in        | cfg_we_i               | cfg_wdata_i  (arena bytes)
//  in      | in        | in_valid_i / in_stall_o  | in_item_i
//  out     | out       | out_valid_o / out_stall_i| out_item_o
//
// One item at a time; in_stall_o is high from the transfer until the result is loaded.
// Alloc: a next-fit walk over the block headers from the rover, then take with optional split.
// Free: ignored unless the offset names a used block, else mark and merge with free neighbours;
// realloc: in place when it fits or can grow into the next free block, else a move: an alloc and a free.
// Init: a clearing pass of one header per cycle over all ARENA_BYTES / WORD_BYTES headers.
// The out register holds a result until taken; the next item transfers meanwhile.
module next_fit_heap_allocator #(
  parameter int unsigned ARENA_BYTES  = nfha_pkg::ARENA_BYTES_DEF,
  parameter int unsigned WORD_BYTES   = nfha_pkg::WORD_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = nfha_pkg::HEADER_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [nfha_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  nfha_pkg::in_item_t         in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output nfha_pkg::out_item_t        out_item_o
);

  nfha_pkg::dp_cmd_t  cmd;
  nfha_pkg::dp_stat_t stat;

  nfha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  nfha_datapath #(
    .ARENA_BYTES  (ARENA_BYTES),
    .WORD_BYTES   (WORD_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_item_o  (out_item_o)
  );

endmodule

// File: rtl/core/nfha_checker.sv
// Checker: port-level assertions for the heap allocator, bound to the top level.
module nfha_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_we_i,
  input logic [nfha_pkg::CFG_W-1:0] cfg_wdata_i,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input nfha_pkg::in_item_t         in_item_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input nfha_pkg::out_item_t        out_item_o
);

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without pending item");

  a_oom_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == nfha_pkg::ST_OOM) |->
      (out_item_o.result_offset == '0 && out_item_o.copy_bytes == '0))
    else $error("out of memory with nonzero result");

  a_moved_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == nfha_pkg::ST_MOVED) |->
      (out_item_o.result_offset != '0 && out_item_o.copy_bytes != '0))
    else $error("move without copy size");

endmodule

bind next_fit_heap_allocator nfha_checker u_nfha_checker (.*);

// File: tb/sv/next_fit_heap_allocator_tb.sv
// Testbench for next_fit_heap_allocator: random heap traffic checked against a heap predictor.
`timescale 1ns / 1ps

module next_fit_heap_allocator_tb;

  localparam int unsigned NW  = 512;
  localparam int unsigned WB  = 8;
  localparam int unsigned HDB = 24;

  typedef struct {
    int unsigned prev;
    int unsigned next;
    int unsigned size;
    bit          free;
  } head_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [nfha_pkg::CFG_W-1:0]    cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  nfha_pkg::in_item_t            in_item_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  nfha_pkg::out_item_t           out_item_o;

  next_fit_heap_allocator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  head_t                 heads[NW];
  int unsigned           rover_w;
  int unsigned           arena_cfg = 4096;
  nfha_pkg::in_item_t    pending_ops[$];
  nfha_pkg::out_item_t   expected_res[$];
  int unsigned           live_offs[$];
  int                    err_cnt = 0;
  int                    in_cnt = 0;
  bit                    hold_long = 1'b0;
  logic                  in_stall_seen = 1'b0;
  int                    burst_left = 0;
  int                    gap_left = 0;

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  function automatic bit adjacent(int unsigned a, int unsigned b);
    return a * WB + HDB + heads[a].size == b * WB;
  endfunction

  function automatic int unsigned round_up(int unsigned r);
    int unsigned n;
    n = (r < WB) ? WB : r;
    return (n + WB - 1) / WB * WB;
  endfunction

  function automatic int unsigned heap_alloc(int unsigned req);
    int unsigned n, node, left, s;
    n = round_up(req);
    node = rover_w % NW;
    for (int c = 0; c < NW; c++) begin
      if (heads[node].free && heads[node].size >= n) begin
        left = heads[node].size - n;
        if (left >= HDB + WB) begin
          s = (node + (HDB + n) / WB) % NW;
          heads[s].prev = node;
          heads[s].next = heads[node].next;
          heads[s].size = left - HDB;
          heads[s].free = 1'b1;
          heads[heads[node].next % NW].prev = s;
          heads[node].next = s;
          heads[node].size = n;
        end
        heads[node].free = 1'b0;
        rover_w = heads[node].next % NW;
        return node * WB + HDB;
      end
      node = heads[node].next % NW;
      if (node == rover_w % NW) break;
    end
    return 0;
  endfunction

  function automatic void heap_free(int unsigned w);
    int unsigned p, nx, wn, nn;
    heads[w].free = 1'b1;
    p = heads[w].prev % NW;
    if (p != w && heads[p].free && adjacent(p, w)) begin
      wn = heads[w].next % NW;
      heads[p].size += HDB + heads[w].size;
      heads[p].next = wn;
      heads[wn].prev = p;
      heads[w] = '{0, 0, 0, 1'b0};
      w = p;
    end
    nx = heads[w].next % NW;
    if (nx != w && heads[nx].free && adjacent(w, nx)) begin
      nn = heads[nx].next % NW;
      heads[w].size += HDB + heads[nx].size;
      heads[w].next = nn;
      heads[nn].prev = w;
      heads[nx] = '{0, 0, 0, 1'b0};
    end
    rover_w = w;
  endfunction

  function automatic bit find_used(int unsigned off, output int unsigned w);
    int unsigned d;
    w = 0;
    if (off < HDB) return 0;
    d = off - HDB;
    if (d % WB != 0 || d / WB >= NW) return 0;
    w = d / WB;
    return heads[w].size != 0 && !heads[w].free;
  endfunction

  function automatic nfha_pkg::out_item_t heap_step(nfha_pkg::in_item_t it);
    nfha_pkg::out_item_t r;
    int unsigned w, n, nx, total, nn, left, s, old, a, ro;
    bit          grown;
    r = '0;
    r.status = nfha_pkg::ST_DONE;
    case (it.operation)
      nfha_pkg::OP_ALLOC: begin
        ro = heap_alloc(it.request_bytes);
        r.result_offset = ro[nfha_pkg::OFF_W-1:0];
        r.status = r.result_offset != 0 ? nfha_pkg::ST_DONE : nfha_pkg::ST_OOM;
      end
      nfha_pkg::OP_FREE: begin
        if (find_used(it.block_offset, w)) heap_free(w);
      end
      nfha_pkg::OP_REALLOC: begin
        if (it.block_offset == 0) begin
          ro = heap_alloc(it.request_bytes);
          r.result_offset = ro[nfha_pkg::OFF_W-1:0];
          r.status = r.result_offset != 0 ? nfha_pkg::ST_DONE : nfha_pkg::ST_OOM;
        end else if (!find_used(it.block_offset, w)) begin
          r.status = nfha_pkg::ST_OOM;
        end else begin
          n = round_up(it.request_bytes);
          nx = heads[w].next % NW;
          grown = 1'b0;
          if (n <= heads[w].size) begin
            r.result_offset = it.block_offset;
            grown = 1'b1;
          end else if (nx != w && heads[nx].free && adjacent(w, nx)) begin
            total = heads[w].size + HDB + heads[nx].size;
            if (total >= n) begin
              nn = heads[nx].next % NW;
              left = total - n;
              heads[nx] = '{0, 0, 0, 1'b0};
              if (left >= HDB + WB) begin
                s = (w + (HDB + n) / WB) % NW;
                heads[s] = '{w, nn, left - HDB, 1'b1};
                heads[nn].prev = s;
                heads[w].next = s;
                heads[w].size = n;
                if (rover_w == nx) rover_w = s;
              end else begin
                heads[w].size = total;
                heads[w].next = nn;
                heads[nn].prev = w;
                if (rover_w == nx) rover_w = nn;
              end
              r.result_offset = it.block_offset;
              grown = 1'b1;
            end
          end
          if (!grown) begin
            old = heads[w].size;
            ro = heap_alloc(it.request_bytes);
            r.result_offset = ro[nfha_pkg::OFF_W-1:0];
            if (r.result_offset != 0) begin
              heap_free(w);
              r.status = nfha_pkg::ST_MOVED;
              r.copy_bytes = old[nfha_pkg::CPY_W-1:0];
            end else begin
              r.status = nfha_pkg::ST_OOM;
            end
          end
        end
      end
      default: begin
        a = arena_cfg;
        if (a > 4096) a = 4096;
        a = a / WB * WB;
        if (a < nfha_pkg::MIN_ARENA) a = nfha_pkg::MIN_ARENA;
        foreach (heads[i]) heads[i] = '{0, 0, 0, 1'b0};
        heads[0] = '{0, 0, a - HDB, 1'b1};
        rover_w = 0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i) in_stall_seen <= in_stall_o;

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_seen) begin
        if (in_valid_i) begin
          if (burst_left > 0) burst_left--;
          else gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
          if (gap_left == 0) burst_left = $urandom_range(0, 20);
        end else if (pending_ops.size() > 0) begin
          in_item_i <= pending_ops.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (hold_long) out_stall_i <= 1'b1;
      else out_stall_i <= ($urandom_range(0, 99) < 30) && ($time % 4000 < 2500);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    nfha_pkg::out_item_t got, want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_res.push_back(heap_step(in_item_i));
        in_cnt++;
      end
      if (out_valid_o && !out_stall_i) begin
        got = out_item_o;
        if (expected_res.size() == 0) begin
          report("unexpected transfer", got.result_offset, 0);
        end else begin
          want = expected_res.pop_front();
          if (got.result_offset != want.result_offset)
            report("result_offset", got.result_offset, want.result_offset);
          if (got.status != want.status) report("status", got.status, want.status);
          if (got.copy_bytes != want.copy_bytes)
            report("copy_bytes", got.copy_bytes, want.copy_bytes);
        end
      end
    end
  end

  // long receiver hold while items keep coming
  initial begin
    wait (in_cnt >= 600);
    @(posedge clk_i);
    hold_long = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_long = 1'b0;
  end

  function automatic nfha_pkg::in_item_t mk(nfha_pkg::op_e op, int unsigned req,
                                            int unsigned off);
    nfha_pkg::in_item_t it;
    it.operation = op;
    it.request_bytes = req[nfha_pkg::REQ_W-1:0];
    it.block_offset = off[nfha_pkg::OFF_W-1:0];
    return it;
  endfunction

  // random offset: mostly a plausible live one, sometimes garbage
  function automatic int unsigned pick_off();
    if (live_offs.size() > 0 && $urandom_range(0, 9) < 8)
      return live_offs[$urandom_range(0, live_offs.size() - 1)];
    return $urandom_range(0, 4095);
  endfunction

  function automatic int unsigned pick_req();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 8191);
      1: return $urandom_range(0, 4096);
      2, 3: return $urandom_range(0, 600);
      default: return $urandom_range(0, 120);
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_ops.size() > 0 || in_valid_i || expected_res.size() > 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic set_arena(int unsigned v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[nfha_pkg::CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    arena_cfg = v;
  endtask

  initial begin
    int unsigned arenas[8] = '{4096, 64, 8191, 0, 100, 4095, 512, 1000};
    int unsigned r;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed
    pending_ops.push_back(mk(nfha_pkg::OP_INIT, 0, 0));
    pending_ops.push_back(mk(nfha_pkg::OP_ALLOC, 0, 0));
    pending_ops.push_back(mk(nfha_pkg::OP_ALLOC, 8191, 4095));
    pending_ops.push_back(mk(nfha_pkg::OP_ALLOC, 1, 0));
    pending_ops.push_back(mk(nfha_pkg::OP_ALLOC, 40, 0));
    pending_ops.push_back(mk(nfha_pkg::OP_FREE, 0, 0));
    pending_ops.push_back(mk(nfha_pkg::OP_FREE, 0, 25));
    pending_ops.push_back(mk(nfha_pkg::OP_FREE, 0, 4095));
    pending_ops.push_back(mk(nfha_pkg::OP_FREE, 0, 56));
    pending_ops.push_back(mk(nfha_pkg::OP_FREE, 0, 56));
    pending_ops.push_back(mk(nfha_pkg::OP_REALLOC, 16, 24));
    pending_ops.push_back(mk(nfha_pkg::OP_REALLOC, 100, 24));
    pending_ops.push_back(mk(nfha_pkg::OP_REALLOC, 300, 0));
    pending_ops.push_back(mk(nfha_pkg::OP_REALLOC, 8, 56));
    pending_ops.push_back(mk(nfha_pkg::OP_REALLOC, 4000, 24));
    pending_ops.push_back(mk(nfha_pkg::OP_REALLOC, 5000, 24));
    pending_ops.push_back(mk(nfha_pkg::OP_ALLOC, 4096, 0));
    pending_ops.push_back(mk(nfha_pkg::OP_INIT, 8191, 4095));
    pending_ops.push_back(mk(nfha_pkg::OP_ALLOC, 4072, 0));
    pending_ops.push_back(mk(nfha_pkg::OP_ALLOC, 8, 0));
    wait_idle();
    // random phases across arena settings
    for (int ph = 0; ph < 8; ph++) begin
      set_arena(arenas[ph]);
      live_offs.delete();
      pending_ops.push_back(mk(nfha_pkg::OP_INIT, $urandom_range(0, 8191),
                               $urandom_range(0, 4095)));
      for (int k = 0; k < 210; k++) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          pending_ops.push_back(mk(nfha_pkg::OP_ALLOC, pick_req(), $urandom_range(0, 4095)));
          live_offs.push_back(24 + 8 * $urandom_range(0, 200));
        end else if (r < 70) begin
          pending_ops.push_back(mk(nfha_pkg::OP_FREE, $urandom_range(0, 8191), pick_off()));
        end else if (r < 97) begin
          pending_ops.push_back(mk(nfha_pkg::OP_REALLOC, pick_req(),
                                   $urandom_range(0, 3) == 0 ? 0 : pick_off()));
        end else begin
          pending_ops.push_back(mk(nfha_pkg::OP_INIT, $urandom_range(0, 8191),
                                   $urandom_range(0, 4095)));
        end
      end
      wait_idle();
    end
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #100ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
